[rtl/core/swm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swm_pkg: shared types for the sliding window median filter
// Holds the data and window-length widths, the controller states and the
// command and status groups that connect the controller to the datapath.
// ---------------------------------------------------------------------------
package swm_pkg;

	localparam int DATA_W = 32;
	localparam int WLEN_W = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_MEDIAN,
		ST_REMOVE
	} swm_state_t;

	typedef struct packed {
		logic load;
		logic insert;
		logic emit;
		logic remove;
	} swm_cmd_t;

	typedef struct packed {
		logic full;
		logic out_free;
	} swm_status_t;

endpackage
`default_nettype wire

[rtl/core/swm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swm_ctrl: sequencer of the sliding window median filter
// Steps each sample through load and sorted insertion and, once the window is
// full, through median output and removal of the oldest sample.
// ---------------------------------------------------------------------------
module swm_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  swm_pkg::swm_status_t status,
	output swm_pkg::swm_cmd_t    cmd
);
	import swm_pkg::*;

	swm_state_t state_q;
	swm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = status.full ? ST_MEDIAN : ST_IDLE;
			end
			ST_MEDIAN: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_REMOVE;
				end
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/swm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swm_datapath: sample ring, sorted cell row and output register
// The ring is a memory in arrival order; the sorted window is a row of
// cells that each compare against the new or the oldest sample and shift.
// ---------------------------------------------------------------------------
module swm_datapath #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [swm_pkg::WLEN_W-1:0]       cfg_wdata,
	input  wire  signed [swm_pkg::DATA_W-1:0] in_sample,
	input  wire                              in_restart,
	input  swm_pkg::swm_cmd_t                cmd,
	output swm_pkg::swm_status_t             status,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic signed [swm_pkg::DATA_W-1:0] out_median
);
	import swm_pkg::*;

	localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int SW = SAMPLE_WIDTH;

	logic [CW-1:0]          k_q;
	logic [CW-1:0]          fill_q;
	logic [PW-1:0]          oldest_q;
	logic signed [SW-1:0]   x_s1;
	logic                   fwd_q;
	logic signed [SW-1:0]   ring_rd_q;
	logic signed [SW-1:0]   ring_mem [MAX_WINDOW];
	logic signed [SW-1:0]   cells_q [MAX_WINDOW];
	logic                   out_valid_q;
	logic signed [DATA_W-1:0] out_data_q;

	logic [63:0]            in_wide;
	logic signed [SW-1:0]   x_new;
	logic                   empty_win;
	logic [CW-1:0]          n_eff;
	logic [PW-1:0]          ptr_eff;
	logic [CW:0]            slot_sum;
	logic [CW:0]            slot_wrap;
	logic [PW-1:0]          slot;
	logic signed [SW-1:0]   old_val;
	logic [MAX_WINDOW-1:0]  gt_new;
	logic [MAX_WINDOW-1:0]  ge_old;
	logic [CW-1:0]          mid;
	logic signed [SW-1:0]   mid_val;
	logic [63:0]            mid_wide;
	logic [CW-1:0]          k_new;
	logic [CW-1:0]          oldest_inc;

	assign in_wide = {{32{in_sample[DATA_W-1]}}, in_sample};
	assign x_new   = in_wide[SW-1:0];

	assign empty_win = in_restart || (fill_q >= k_q) || (CW'(oldest_q) >= k_q);
	assign n_eff     = empty_win ? '0 : fill_q;
	assign ptr_eff   = empty_win ? '0 : oldest_q;
	assign slot_sum  = (CW+1)'(ptr_eff) + (CW+1)'(n_eff);
	assign slot_wrap = (slot_sum >= (CW+1)'(k_q)) ? slot_sum - (CW+1)'(k_q) : slot_sum;
	assign slot      = slot_wrap[PW-1:0];

	assign old_val = fwd_q ? x_s1 : ring_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ring_mem[slot] <= x_new;
			ring_rd_q      <= ring_mem[ptr_eff];
			x_s1           <= x_new;
			fwd_q          <= (slot == ptr_eff);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			gt_new[i] = (CW'(i) >= fill_q) || (x_s1 < cells_q[i]);
			ge_old[i] = !(cells_q[i] < old_val);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (cmd.insert && gt_new[i]) begin
				if (i == 0) begin
					cells_q[i] <= x_s1;
				end else if (!gt_new[(i > 0) ? i - 1 : 0]) begin
					cells_q[i] <= x_s1;
				end else begin
					cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
				end
			end else if (cmd.remove && ge_old[i] && (i < MAX_WINDOW - 1)) begin
				cells_q[i] <= cells_q[(i < MAX_WINDOW - 1) ? i + 1 : i];
			end
		end
	end

	assign mid      = (k_q - CW'(1)) >> 1;
	assign mid_val  = cells_q[mid[PW-1:0]];
	assign mid_wide = {{(64-SW){mid_val[SW-1]}}, mid_val};

	always_comb begin
		if (cfg_wdata == '0) begin
			k_new = CW'(1);
		end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
			k_new = CW'(MAX_WINDOW);
		end else begin
			k_new = CW'(cfg_wdata);
		end
	end

	assign oldest_inc = CW'(oldest_q) + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= CW'(1);
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (cfg_we) begin
			k_q      <= k_new;
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (cmd.load) begin
			fill_q   <= n_eff;
			oldest_q <= ptr_eff;
		end else if (cmd.insert) begin
			fill_q <= fill_q + CW'(1);
		end else if (cmd.remove) begin
			fill_q   <= fill_q - CW'(1);
			oldest_q <= (oldest_inc == k_q) ? '0 : oldest_inc[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= mid_wide[DATA_W-1:0];
		end
	end

	assign status.full     = (fill_q == k_q - CW'(1));
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_median      = out_data_q;

endmodule
`default_nettype wire

[rtl/core/sliding_window_median.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sliding_window_median: lower median over a sliding window of samples
// Keeps the last K samples in a ring and a sorted copy in a cell row, and
// gives the lower median once the window is full.
// ---------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: sample; tuser: restart
// m_axis    out        tdata: median
// cfg       in         window_length, written when cfg_we is high
//
// A sample that does not fill the window goes through load and sorted
// insert; one that gives a result then goes on to median and removal of
// the oldest. The median waits in an output register, so a stalled m_axis
// holds the block only when the next median is ready. Reset leaves the
// window empty with a length of 1; no clearing pass follows reset.
// ---------------------------------------------------------------------------
module sliding_window_median #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [swm_pkg::WLEN_W-1:0]        cfg_wdata,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire  signed [swm_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] sample
	input  wire  [0:0]                        s_axis_tuser,  // [0] restart
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic signed [swm_pkg::DATA_W-1:0] m_axis_tdata   // [31:0] median
);
	import swm_pkg::*;

	swm_cmd_t    cmd;
	swm_status_t status;

	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	swm_datapath #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_sample  (s_axis_tdata),
		.in_restart (s_axis_tuser[0]),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_median (m_axis_tdata)
	);

endmodule
`default_nettype wire
